// ----- hw/rtl/rmewb_pkg.sv -----
// Package for the run-merge equal-weight binner.
// Field widths, bin limit, status and register codes, controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package rmewb_pkg;

  localparam int ITEMS_W   = 36;  // total_weight, items_left, bin_fill
  localparam int WEIGHT_W  = 15;  // group weight
  localparam int BIN_W     = 8;   // bin number on the output
  localparam int BIN_CNT_W = 9;   // bin_count register, current bin
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // largest usable bin count; bin_count above this clamps
  localparam int MAX_BINS  = 256;

  localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX       = '1;
  localparam logic [BIN_CNT_W-1:0] BIN_COUNT_RST    = 9'd16;
  localparam logic [ITEMS_W-1:0]   TOTAL_WEIGHT_RST = 36'd1326;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNDERUSED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_WEIGHT = 2'd1;

  typedef struct packed {
    logic load_item;    // capture input word
    logic start_batch;  // first item of a batch
    logic merge;        // same index, bump weight
    logic div_start;    // items_left / bins_left
    logic decide;       // register open-new-bin decision
    logic place;        // bin the run and load the output register
    logic place_last;   // this group closes the batch
    logic new_run;      // after placing, the held item opens a new run
  } rmewb_cmd_t;

  typedef struct packed {
    logic run_open;
    logic idx_match;
    logic item_last;
    logic div_busy;
    logic out_free;
  } rmewb_sts_t;

endpackage

// ----- hw/rtl/rmewb_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on rmewb_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module rmewb_div
  import rmewb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ITEMS_W-1:0]   dividend,
  input  logic [BIN_CNT_W-1:0] divisor,
  output logic                 busy,
  output logic [ITEMS_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(ITEMS_W);

  logic [ITEMS_W-1:0]   quo_r, quo_nxt;
  logic [BIN_CNT_W-1:0] rem_r, rem_nxt;
  logic [BIN_CNT_W-1:0] dsr_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic [BIN_CNT_W:0]   rem_sh;
  logic [BIN_CNT_W:0]   rem_sub;

  // shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, quo_r[ITEMS_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    if (rem_sh >= {1'b0, dsr_r}) begin
      rem_nxt = rem_sub[BIN_CNT_W-1:0];
      quo_nxt = {quo_r[ITEMS_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[BIN_CNT_W-1:0];
      quo_nxt = {quo_r[ITEMS_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ITEMS_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ----- hw/rtl/rmewb_ctrl.sv -----
// Controller state machine of the binner: sequences accept, merge,
// divide, decide and place. Depends on rmewb_pkg for the cmd/sts structs.
`timescale 1ns / 1ps

module rmewb_ctrl
  import rmewb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  rmewb_sts_t sts,
  output rmewb_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DWAIT  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_PLACE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       pl_r, pl_nxt;      // group being placed is the last one
  logic       nr_r, nr_nxt;      // held item opens a new run after placing
  logic       pend_r, pend_nxt;  // a last one-item group follows

  always_comb begin
    state_nxt = state_r;
    pl_nxt    = pl_r;
    nr_nxt    = nr_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready     = 1'b1;
        cmd.load_item = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        pend_nxt = 1'b0;
        if (!sts.run_open || sts.idx_match) begin
          cmd.start_batch = !sts.run_open;
          cmd.merge       = sts.run_open;
          pl_nxt          = 1'b1;
          nr_nxt          = 1'b0;
          state_nxt       = sts.item_last ? S_DSTART : S_IDLE;
        end else begin
          pl_nxt    = 1'b0;
          nr_nxt    = 1'b1;
          pend_nxt  = sts.item_last;
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_PLACE;
      end
      S_PLACE: begin
        if (sts.out_free) begin
          cmd.place      = 1'b1;
          cmd.place_last = pl_r;
          cmd.new_run    = nr_r;
          if (pend_r) begin
            pl_nxt    = 1'b1;
            nr_nxt    = 1'b0;
            pend_nxt  = 1'b0;
            state_nxt = S_DSTART;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pl_r    <= 1'b0;
      nr_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pl_r    <= pl_nxt;
      nr_r    <= nr_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// ----- hw/rtl/rmewb_dp.sv -----
// Datapath of the binner: config registers, run and bin state, divider,
// placement logic and output register. Depends on rmewb_pkg, rmewb_div.
`timescale 1ns / 1ps

module rmewb_dp
  import rmewb_pkg::*;
#(
  parameter int INDEX_BITS = 36
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [ITEMS_W-1:0]     cfg_wdata,
  input  logic [INDEX_BITS-1:0]  item_index,
  input  logic                   last_item,
  input  rmewb_cmd_t             cmd,
  output rmewb_sts_t             sts,
  input  logic                   out_tready,
  output logic                   out_valid,
  output logic [INDEX_BITS-1:0]  group_index,
  output logic [WEIGHT_W-1:0]    group_weight,
  output logic [BIN_W-1:0]       bin_number,
  output logic                   last_group,
  output logic [STATUS_W-1:0]    status
);

  // config
  logic [BIN_CNT_W-1:0]  bin_count_r;
  logic [ITEMS_W-1:0]    total_weight_r;
  // held input word
  logic [INDEX_BITS-1:0] idx_r;
  logic                  last_r;
  // run and bin state
  logic [INDEX_BITS-1:0] run_index_r;
  logic [WEIGHT_W-1:0]   run_weight_r;
  logic                  run_open_r;
  logic [BIN_CNT_W-1:0]  cur_bin_r;
  logic [ITEMS_W-1:0]    bin_fill_r;
  logic [ITEMS_W-1:0]    items_left_r;
  logic                  adv_r;
  logic                  exh_r;
  // output register
  logic                  out_valid_r;
  logic [INDEX_BITS-1:0] out_idx_r;
  logic [WEIGHT_W-1:0]   out_weight_r;
  logic [BIN_W-1:0]      out_bin_r;
  logic                  out_last_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic [BIN_CNT_W-1:0]  eff;
  logic [BIN_CNT_W-1:0]  bins_left;
  logic                  can_adv;
  logic                  div_busy;
  logic [ITEMS_W-1:0]    quo;
  logic [ITEMS_W:0]      dec_sum;
  logic                  open_new;
  logic [ITEMS_W-1:0]    il_mid;
  logic [BIN_CNT_W-1:0]  cur_mid;
  logic [ITEMS_W-1:0]    fill_base;
  logic [ITEMS_W:0]      fill_sum;
  logic [ITEMS_W-1:0]    fill_new;
  logic [STATUS_W-1:0]   st_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r    <= BIN_COUNT_RST;
      total_weight_r <= TOTAL_WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BIN_COUNT:    bin_count_r    <= cfg_wdata[BIN_CNT_W-1:0];
        REG_TOTAL_WEIGHT: total_weight_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective bin count: zero acts as one, clamp at MAX_BINS
  always_comb begin
    if (bin_count_r == '0) begin
      eff = BIN_CNT_W'(1);
    end else if (32'(bin_count_r) > MAX_BINS) begin
      eff = BIN_CNT_W'(MAX_BINS);
    end else begin
      eff = bin_count_r;
    end
    bins_left = (cur_bin_r < eff) ? eff - cur_bin_r : BIN_CNT_W'(1);
    can_adv   = ({1'b0, cur_bin_r} + 1'b1) < {1'b0, eff};
  end

  rmewb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (items_left_r),
    .divisor  (bins_left),
    .busy     (div_busy),
    .quotient (quo)
  );

  // open a new bin when the bin is not empty and fill + w/2 exceeds the fair share
  always_comb begin
    dec_sum  = {1'b0, bin_fill_r} + (ITEMS_W+1)'(run_weight_r[WEIGHT_W-1:1]);
    open_new = (bin_fill_r != '0) && (dec_sum > {1'b0, quo});
  end

  always_comb begin
    if (adv_r) begin
      il_mid    = (items_left_r > bin_fill_r) ? items_left_r - bin_fill_r : '0;
      cur_mid   = cur_bin_r + 1'b1;
      fill_base = '0;
    end else begin
      il_mid    = items_left_r;
      cur_mid   = cur_bin_r;
      fill_base = bin_fill_r;
    end
    fill_sum = {1'b0, fill_base} + (ITEMS_W+1)'(run_weight_r);
    fill_new = fill_sum[ITEMS_W] ? '1 : fill_sum[ITEMS_W-1:0];
    st_new   = exh_r ? ST_EXHAUSTED : ST_OK;
    if (cmd.place_last) begin
      if (fill_new != il_mid) begin
        st_new = ST_MISMATCH;
      end else if (!exh_r && (({1'b0, cur_mid} + 1'b1) < {1'b0, eff})) begin
        st_new = ST_UNDERUSED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      idx_r  <= item_index;
      last_r <= last_item;
    end
    if (cmd.decide) begin
      adv_r <= open_new && can_adv;
      exh_r <= open_new && !can_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r   <= 1'b0;
      run_index_r  <= '0;
      run_weight_r <= '0;
      cur_bin_r    <= '0;
      bin_fill_r   <= '0;
      items_left_r <= TOTAL_WEIGHT_RST;
    end else if (cmd.start_batch) begin
      run_open_r   <= 1'b1;
      run_index_r  <= idx_r;
      run_weight_r <= WEIGHT_W'(1);
      cur_bin_r    <= '0;
      bin_fill_r   <= '0;
      items_left_r <= total_weight_r;
    end else if (cmd.merge) begin
      if (run_weight_r != WEIGHT_MAX) begin
        run_weight_r <= run_weight_r + 1'b1;
      end
    end else if (cmd.place) begin
      cur_bin_r    <= cur_mid;
      bin_fill_r   <= fill_new;
      items_left_r <= il_mid;
      if (cmd.new_run) begin
        run_index_r  <= idx_r;
        run_weight_r <= WEIGHT_W'(1);
      end
      if (cmd.place_last) begin
        run_open_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.place) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      out_idx_r    <= run_index_r;
      out_weight_r <= run_weight_r;
      out_bin_r    <= cur_mid[BIN_W-1:0];
      out_last_r   <= cmd.place_last;
      out_status_r <= st_new;
    end
  end

  always_comb begin
    sts.run_open  = run_open_r;
    sts.idx_match = (idx_r == run_index_r);
    sts.item_last = last_r;
    sts.div_busy  = div_busy;
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_valid    = out_valid_r;
  assign group_index  = out_idx_r;
  assign group_weight = out_weight_r;
  assign bin_number   = out_bin_r;
  assign last_group   = out_last_r;
  assign status       = out_status_r;

endmodule

// ----- hw/rtl/run_merge_equal_weight_binner_unit.sv -----
// Top level of the run-merge equal-weight binner.
// Depends on rmewb_pkg, rmewb_ctrl, rmewb_dp (which holds rmewb_div).
//
//   port group | dir | word contents
//   in_*       | in  | tdata: item_index; tlast: last_item
//   out_*      | out | tdata: group_index, group_weight, bin_number;
//              |     | tlast: last_group; tuser: status
//   cfg_*      | in  | write-only: 0 bin_count, 1 total_weight
//
// Sequence: a word that only extends or opens a run is accepted, then
// evaluated; each finished group adds start, a 36-step restoring divide of
// items_left by the bins left, a done check, decide and place.
// Reset (rst_n low, synchronous) loads bin_count 16, total_weight 1326
// and closes any open run. A waiting result sits in the output register
// while the next word is taken; placement stalls only if it is still full.
`timescale 1ns / 1ps

module run_merge_equal_weight_binner_unit
  import rmewb_pkg::*;
#(
  parameter int INDEX_BITS = 36,
  localparam int IN_DATA_W  = ((INDEX_BITS + 7) / 8) * 8,
  localparam int PACK_W     = INDEX_BITS + WEIGHT_W + BIN_W,
  localparam int OUT_DATA_W = ((PACK_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // item_index
  input  logic                  in_tlast,   // last_item
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // group_index, group_weight, bin_number
  output logic                  out_tlast,  // last_group
  output logic [STATUS_W-1:0]   out_tuser,  // status
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ITEMS_W-1:0]    cfg_wdata
);

  rmewb_cmd_t            cmd;
  rmewb_sts_t            sts;
  logic [INDEX_BITS-1:0] group_index;
  logic [WEIGHT_W-1:0]   group_weight;
  logic [BIN_W-1:0]      bin_number;

  rmewb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmewb_dp #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .item_index   (in_tdata[INDEX_BITS-1:0]),
    .last_item    (in_tlast),
    .cmd          (cmd),
    .sts          (sts),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .group_index  (group_index),
    .group_weight (group_weight),
    .bin_number   (bin_number),
    .last_group   (out_tlast),
    .status       (out_tuser)
  );

  // pack result word, lowest field first, zero pad to bytes
  always_comb begin
    out_tdata             = '0;
    out_tdata[PACK_W-1:0] = {bin_number, group_weight, group_index};
  end

endmodule

// ----- hw/rtl/rmewb_chk.sv -----
// Port-level checks for the binner, bound to the top level.
// Depends on rmewb_pkg for status codes.
`timescale 1ns / 1ps

module rmewb_chk
  import rmewb_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic                out_tlast,
  input logic [STATUS_W-1:0] out_tuser
);

  // a result waiting for the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one word at a time: ready falls after every accepted word
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

  // end-of-batch codes only on the last group
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_MISMATCH || out_tuser == ST_UNDERUSED)
      |-> out_tlast)
    else $error("end status on a non-final group");

  // reset empties the output register
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind run_merge_equal_weight_binner_unit rmewb_chk u_rmewb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ----- sim/tb.sv -----
// Self-checking bench for run_merge_equal_weight_binner_unit: sorted item words in,
// binned groups out, compared against an in-bench model of the merge and bin logic.
// Depends on rmewb_pkg and the RTL of the unit; nothing else.
`timescale 1ns / 1ps

module tb
  import rmewb_pkg::*;
();

  localparam int INDEX_BITS = 36;
  localparam int IN_DATA_W  = ((INDEX_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((INDEX_BITS + WEIGHT_W + BIN_W + 7) / 8) * 8;

  localparam logic [INDEX_BITS-1:0] IDX_MAX  = '1;
  localparam longint unsigned       FILL_MAX = (64'd1 << ITEMS_W) - 1;
  // slowest legal run stays well under 4 ms; this is over 10x that
  localparam longint unsigned       RUN_LIMIT_NS = 64'd50_000_000;

  // one finished group as it shows up on the result stream
  typedef struct {
    logic [INDEX_BITS-1:0] index;
    logic [WEIGHT_W-1:0]   weight;
    logic [BIN_W-1:0]      bin;
    logic                  last;
    logic [STATUS_W-1:0]   status;
  } group_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // item_index
  logic                  in_tlast;   // last_item
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // group_index, group_weight, bin_number
  logic                  out_tlast;  // last_group
  logic [STATUS_W-1:0]   out_tuser;  // status
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [ITEMS_W-1:0]    cfg_wdata;

  // groups the model says are on their way, oldest first
  group_t groups_due[$];
  int     fail_cnt   = 0;
  int     words_sent = 0;

  // stimulus knobs, flipped by the tests
  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  int hold_req  = 0;   // one-shot long hold-off of out_tready, in cycles

  // model copy of the registers and the binning state
  logic [BIN_CNT_W-1:0]  bins_cfg;
  longint unsigned       total_cfg;
  logic [INDEX_BITS-1:0] run_idx;
  int unsigned           run_wt;
  bit                    run_live;
  int unsigned           cur_bin;
  longint unsigned       bin_fill;
  longint unsigned       items_left;

  run_merge_equal_weight_binner_unit #(
    .INDEX_BITS (INDEX_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // Place the open run into a bin and queue the group it produces.
  function automatic void bin_group(input bit last_g);
    longint unsigned     eff;
    longint unsigned     bins_left;
    longint unsigned     w;
    logic [STATUS_W-1:0] st;
    group_t              g;
    // bin_count is read per group; 0 acts as 1, anything past MAX_BINS clamps
    eff = bins_cfg;
    if (eff == 0) eff = 1;
    if (eff > MAX_BINS) eff = MAX_BINS;
    // current bin can sit past the end if bin_count was lowered mid batch
    bins_left = (cur_bin < eff) ? eff - cur_bin : 1;
    w  = run_wt;
    st = ST_OK;
    if (bin_fill > 0 && bin_fill + w / 2 > items_left / bins_left) begin
      if (cur_bin + 1 < eff) begin
        items_left = (items_left > bin_fill) ? items_left - bin_fill : 0;
        cur_bin++;
        bin_fill = 0;
      end else begin
        st = ST_EXHAUSTED;  // no bin left to open: stay put and flag it
      end
    end
    bin_fill += w;
    if (bin_fill > FILL_MAX) bin_fill = FILL_MAX;
    // end-of-batch status: mismatch beats exhausted beats underused
    if (last_g) begin
      if (bin_fill != items_left) st = ST_MISMATCH;
      else if (st == ST_OK && cur_bin + 1 < eff) st = ST_UNDERUSED;
    end
    g.index  = run_idx;
    g.weight = w[WEIGHT_W-1:0];
    g.bin    = cur_bin[BIN_W-1:0];
    g.last   = last_g;
    g.status = st;
    groups_due.push_back(g);
  endfunction

  // One accepted item word: open, extend or close a run.
  function automatic void merge_item(input logic [INDEX_BITS-1:0] idx, input bit last);
    if (!run_live) begin
      // first word of a batch; total_weight is only sampled here
      items_left = total_cfg;
      cur_bin    = 0;
      bin_fill   = 0;
      run_idx    = idx;
      run_wt     = 1;
      run_live   = 1'b1;
    end else if (idx == run_idx) begin
      if (run_wt < WEIGHT_MAX) run_wt++;
    end else begin
      bin_group(1'b0);
      run_idx = idx;
      run_wt  = 1;
    end
    // a last word with a new index gives two groups: old run, then itself
    if (last) begin
      bin_group(1'b1);
      run_live = 1'b0;
    end
  endfunction

  function automatic string show(input group_t g);
    return $sformatf("idx %h wt %0d bin %0d last %0b st %0d",
                     g.index, g.weight, g.bin, g.last, g.status);
  endfunction

  function automatic logic [INDEX_BITS-1:0] rand_index();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[INDEX_BITS-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern and checker
  // ---------------------------------------------------------------------------

  // After each accepted word, while sink_idle is set, the receiver may drop ready.
  // A hold-off request overrides that with one long, counted stall.
  initial begin : ready_driver
    int gap;
    out_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        gap      = hold_req;
        hold_req = 0;
      end else if (out_tvalid && out_tready && sink_idle) begin
        gap = $urandom_range(0, 16);
      end else begin
        gap = 0;
      end
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Values read right after the edge are the ones the edge sampled.
  always @(posedge clk) begin : result_check
    group_t got;
    group_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.index  = out_tdata[INDEX_BITS-1:0];
      got.weight = out_tdata[INDEX_BITS +: WEIGHT_W];
      got.bin    = out_tdata[INDEX_BITS+WEIGHT_W +: BIN_W];
      got.last   = out_tlast;
      got.status = out_tuser;
      if (groups_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected group word: %s", show(got));
      end else begin
        want = groups_due.pop_front();
        if (got.index !== want.index || got.weight !== want.weight ||
            got.bin !== want.bin || got.last !== want.last ||
            got.status !== want.status) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("group mismatch: expected %s / actual %s", show(want), show(got));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one item word and hold it until taken. Valid is only dropped ahead
  // of an idle gap so it never toggles twice in one step.
  task automatic send_word(input logic [INDEX_BITS-1:0] idx, input bit last);
    int gap;
    gap = src_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(idx);
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    merge_item(idx, last);
    words_sent++;
  endtask

  // A wait with cfg_we low after the strobe keeps back-to-back writes apart.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input longint unsigned value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value[ITEMS_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (addr == REG_BIN_COUNT) bins_cfg = value[BIN_CNT_W-1:0];
    else if (addr == REG_TOTAL_WEIGHT) total_cfg = value[ITEMS_W-1:0];
  endtask

  // Stop offering, wait for every queued group, then give the unit time to
  // finish a trailing merge-only word (those produce nothing to wait on).
  task automatic settle();
    int n;
    in_tvalid <= 1'b0;
    n = 0;
    while (groups_due.size() != 0 && n < 50000) begin
      @(posedge clk);
      n++;
    end
    repeat (100) @(posedge clk);
  endtask

  // Well-formed batch: n_groups runs of random weight, distinct neighbors,
  // last flag on the final word. exact_total programs total_weight to match.
  task automatic send_batch(input int n_groups, input int max_w, input bit exact_total);
    int unsigned           weights[$];
    longint unsigned       sum;
    logic [INDEX_BITS-1:0] idx;
    logic [INDEX_BITS-1:0] nxt;
    sum = 0;
    repeat (n_groups) begin
      weights.push_back($urandom_range(1, max_w));
      sum += weights[$];
    end
    if (exact_total) write_reg(REG_TOTAL_WEIGHT, sum);
    idx = rand_index();
    foreach (weights[g]) begin
      if (g != 0) begin
        nxt = rand_index();
        idx = (nxt == idx) ? ~nxt : nxt;
      end
      for (int k = 0; k < weights[g]; k++)
        send_word(idx, g == weights.size() - 1 && k == weights[g] - 1);
    end
  endtask

  // Noise: a few indices shuffled, stray last flags, batches left open.
  task automatic send_noise(input int n);
    logic [INDEX_BITS-1:0] pool[3];
    foreach (pool[i]) pool[i] = rand_index();
    repeat (n) send_word(pool[$urandom_range(0, 2)], $urandom_range(0, 7) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values (16 bins, 1326 items): short batch ending in a two-group
  // word, then a batch whose first word is also its last.
  task automatic test_reset_values();
    send_word(36'h1_2345_6789, 1'b0);
    send_word(36'h1_2345_6789, 1'b0);
    send_word(36'h2_0000_0001, 1'b0);
    send_word(36'h3_0000_0002, 1'b1);
    send_word(36'h4_0000_0003, 1'b1);
    settle();
  endtask

  // Index and total_weight extremes; last word that only extends its run.
  task automatic test_index_extremes();
    write_reg(REG_BIN_COUNT, 1);
    write_reg(REG_TOTAL_WEIGHT, 3);
    send_word('0, 1'b0);
    send_word('0, 1'b0);
    send_word(IDX_MAX, 1'b1);
    settle();
    write_reg(REG_BIN_COUNT, 2);
    write_reg(REG_TOTAL_WEIGHT, FILL_MAX);
    send_word(IDX_MAX, 1'b0);
    send_word('0, 1'b0);
    send_word('0, 1'b1);
    settle();
    write_reg(REG_TOTAL_WEIGHT, 1);
    send_word(36'h5_5555_5555, 1'b1);
    settle();
  endtask

  // Tiny total pushes one bin per group; then bin_count drops below the
  // current bin with the run still open, so the rest report exhaustion, the last a mismatch.
  task automatic test_bins_exhausted();
    write_reg(REG_BIN_COUNT, 16);
    write_reg(REG_TOTAL_WEIGHT, 2);
    for (int g = 0; g < 5; g++) send_word(36'h100 + g, 1'b0);
    settle();
    write_reg(REG_BIN_COUNT, 2);
    send_word(36'h200, 1'b0);
    send_word(36'h201, 1'b0);
    send_word(36'h201, 1'b1);
    settle();
  endtask

  // bin_count 0 acts as one bin; 511 clamps to 256. With total 1 every
  // group opens a bin, so the big batch walks to bin 255 and then saturates.
  task automatic test_bin_count_clamp();
    write_reg(REG_BIN_COUNT, 0);
    write_reg(REG_TOTAL_WEIGHT, 4);
    for (int g = 0; g < 4; g++) send_word(36'hA00 + g, g == 3);
    settle();
    write_reg(REG_BIN_COUNT, (1 << BIN_CNT_W) - 1);
    write_reg(REG_TOTAL_WEIGHT, 1);
    for (int g = 0; g < 258; g++) send_word(36'hF_0000_0000 + g, g == 257);
    settle();
  endtask

  // Receiver stalls in one long hold-off while the sender keeps pushing words,
  // so the output register fills and in_tready has to drop.
  task automatic test_output_backpressure();
    write_reg(REG_BIN_COUNT, 8);
    write_reg(REG_TOTAL_WEIGHT, 24);
    hold_req = 400;
    for (int g = 0; g < 24; g++) send_word(36'hC_0000_0000 + 3 * g, g == 23);
    settle();
  endtask

  // Mostly well-formed batches with random sizes and settings, plus some
  // mismatched totals and noise; idling toggles per phase. Runs until the
  // whole bench has sent at least 440 words.
  task automatic test_random_traffic();
    int              stop_at;
    int              pick;
    longint unsigned bc;
    longint unsigned tw;
    stop_at = 440;
    while (words_sent < stop_at) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       bc = 0;
        1:       bc = 1;
        2:       bc = MAX_BINS;
        3:       bc = $urandom_range(MAX_BINS + 1, (1 << BIN_CNT_W) - 1);
        default: bc = $urandom_range(2, 12);
      endcase
      write_reg(REG_BIN_COUNT, bc);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_batch($urandom_range(1, 12), ($urandom_range(0, 4) == 0) ? 12 : 4, 1'b1);
      end else begin
        case ($urandom_range(0, 3))
          0:       tw = FILL_MAX;
          1:       tw = ({$urandom(), $urandom()} & FILL_MAX) | 64'd1;
          default: tw = $urandom_range(1, 64);
        endcase
        write_reg(REG_TOTAL_WEIGHT, tw);
        if (pick < 9) send_batch($urandom_range(1, 12), 4, 1'b0);
        else send_noise($urandom_range(4, 16));
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : test_sequence
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_BIN_COUNT;
    cfg_wdata = '0;
    // model state after reset
    bins_cfg   = BIN_COUNT_RST;
    total_cfg  = TOTAL_WEIGHT_RST;
    run_idx    = '0;
    run_wt     = 0;
    run_live   = 1'b0;
    cur_bin    = 0;
    bin_fill   = 0;
    items_left = total_cfg;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_index_extremes();
    test_bins_exhausted();
    test_bin_count_clamp();
    test_output_backpressure();
    test_random_traffic();
    settle();

    // anything still queued never came out
    if (groups_due.size() != 0) begin
      $display("%0d expected group words never arrived", groups_due.size());
      fail_cnt += groups_due.size();
    end
    if (fail_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rmewb_pkg.sv
hw/rtl/rmewb_div.sv
hw/rtl/rmewb_ctrl.sv
hw/rtl/rmewb_dp.sv
hw/rtl/run_merge_equal_weight_binner_unit.sv
hw/rtl/rmewb_chk.sv
sim/tb.sv
